[src/cbe_pkg.sv]
// Package: shared constants, the queue entry type and the character table for the encoder.
`default_nettype none

package cbe_pkg;

  localparam int unsigned MaxChunkBytes = 4194304;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned CfgW          = 23;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned SextetW       = 6;
  localparam int unsigned CharW         = 7;

  // Group positions inside a 3-byte group
  typedef enum logic [1:0] {
    GrpFirst  = 2'd0,
    GrpSecond = 2'd1,
    GrpThird  = 2'd2
  } cbe_grp_e;

  // One encoded byte: one or two sextets plus the end flags of the byte
  typedef struct packed {
    logic [SextetW-1:0] six0;
    logic [SextetW-1:0] six1;
    logic               two;
    logic               cend;
    logic               mlast;
  } cbe_entry_t;

  // Status flags that go with one output character
  typedef struct packed {
    logic chunk_end;
    logic message_end;
    logic run_last;
  } cbe_flags_t;

  // base64url alphabet: A-Z, a-z, 0-9, '-', '_'
  function automatic logic [CharW-1:0] sextet_to_ascii(input logic [SextetW-1:0] v);
    logic [CharW-1:0] c;
    logic [CharW-1:0] vx;
    vx = {1'b0, v};
    if (v < 6'd26) begin
      c = vx + 7'd65;
    end else if (v < 6'd52) begin
      c = vx + 7'd71;
    end else if (v < 6'd62) begin
      c = vx - 7'd4;
    end else if (v == 6'd62) begin
      c = 7'd45;
    end else begin
      c = 7'd95;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/chunked_base64url_encoder.sv]
// Top level: chunked unpadded base64url encoder (front end, entry queue, back end).
//
//   channel   direction  handshake              beat contents
//   -------   ---------  ---------------------  --------------------------------------
//   input     in         push / full            data_byte_i, message_last_i
//   result    out        empty / pop            char_code_o, chunk_end_o, message_end_o,
//                                               run_last_o
//   config    in         cfg_valid_i/cfg_ready_o cfg_data_i (chunk size, bytes)
//
// The front end takes one byte per cycle whenever the entry queue has room; each byte
// becomes one queue entry of one or two characters. The back end emits one character
// beat per cycle while entries wait and the result port is popped; a byte at a chunk end
// yields 2 beats, 3 bytes mid-chunk yield 4. A byte's first character goes through the
// queue and then the output register. Reset clears all control state and sets the
// chunk size to its maximum. Either side may stall freely; the queue absorbs it.
`default_nettype none

module chunked_base64url_encoder #(
  parameter int unsigned MAX_CHUNK_BYTES = cbe_pkg::MaxChunkBytes,
  parameter int unsigned QUEUE_DEPTH     = cbe_pkg::QueueDepth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // config write channel
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [cbe_pkg::CfgW-1:0]   cfg_data_i,
  // byte input
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [cbe_pkg::ByteW-1:0]  data_byte_i,
  input  wire logic                       message_last_i,
  // character output
  output logic                            empty,
  input  wire logic                       pop,
  output logic [cbe_pkg::CharW-1:0]       char_code_o,
  output logic                            chunk_end_o,
  output logic                            message_end_o,
  output logic                            run_last_o
);
  import cbe_pkg::*;

  cbe_entry_t fe_entry;
  cbe_entry_t q_head;
  cbe_flags_t flags;
  logic       take;
  logic       q_empty;
  logic       q_rd;

  // a byte beat is taken whenever the queue has room
  assign take = push && !full;

  cbe_front #(
    .MAX_CHUNK_BYTES(MAX_CHUNK_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .take_i        (take),
    .data_byte_i   (data_byte_i),
    .message_last_i(message_last_i),
    .entry_o       (fe_entry)
  );

  cbe_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (take),
    .wdata_i(fe_entry),
    .full_o (full),
    .rd_i   (q_rd),
    .rdata_o(q_head),
    .empty_o(q_empty)
  );

  cbe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_head),
    .q_rd_o     (q_rd),
    .empty_o    (empty),
    .pop_i      (pop),
    .char_code_o(char_code_o),
    .flags_o    (flags)
  );

  assign chunk_end_o   = flags.chunk_end;
  assign message_end_o = flags.message_end;
  assign run_last_o    = flags.run_last;

`ifndef SYNTHESIS
  // a message end always closes the chunk and the byte's run
  a_mend_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && message_end_o) |-> (chunk_end_o && run_last_o))
    else $error("message end without chunk end or run end");

  // chunk end only on the last character of a byte
  a_cend_on_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && chunk_end_o) |-> run_last_o)
    else $error("chunk end on a non-final character");

  // an idle output register is refilled from a waiting entry
  a_back_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !q_empty) |=> !empty)
    else $error("output register not loaded from queue");

  // an accepted byte lands in the queue
  a_take_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> !q_empty)
    else $error("accepted byte missing from queue");
`endif

endmodule

`default_nettype wire

[src/cbe_front.sv]
// Front end: config register, byte intake, group/chunk tracking and sextet split.
`default_nettype none

module cbe_front #(
  parameter int unsigned MAX_CHUNK_BYTES = cbe_pkg::MaxChunkBytes
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [cbe_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                        take_i,
  input  wire logic [cbe_pkg::ByteW-1:0]   data_byte_i,
  input  wire logic                        message_last_i,
  output cbe_pkg::cbe_entry_t              entry_o
);
  import cbe_pkg::*;

  localparam int unsigned CntW = (MAX_CHUNK_BYTES > 1) ? $clog2(MAX_CHUNK_BYTES) : 1;
  localparam logic [CfgW-1:0] MaxSz  = CfgW'(MAX_CHUNK_BYTES);
  localparam logic [CntW-1:0] LimRst = CntW'(MAX_CHUNK_BYTES - 1);

  // lim_q holds effective chunk size minus one
  logic [CntW-1:0] lim_q, lim_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  cbe_grp_e        grp_q, grp_d;
  logic [3:0]      left_q, left_d;
  logic            cend;
  logic [ByteW-1:0] b;

  assign cfg_ready_o = 1'b1;
  assign b = data_byte_i;

  always_comb begin
    if (cfg_data_i == '0) begin
      lim_d = '0;
    end else if (cfg_data_i > MaxSz) begin
      lim_d = LimRst;
    end else begin
      lim_d = CntW'(cfg_data_i - 1'b1);
    end
  end

  assign cend = message_last_i || (cnt_q >= lim_q);

  always_comb begin
    entry_o.cend  = cend;
    entry_o.mlast = message_last_i;
    unique case (grp_q)
      GrpFirst: begin
        entry_o.six0 = b[7:2];
        entry_o.six1 = {b[1:0], 4'b0000};
        entry_o.two  = cend;
        left_d       = {2'b00, b[1:0]};
        grp_d        = GrpSecond;
      end
      GrpSecond: begin
        entry_o.six0 = {left_q[1:0], b[7:4]};
        entry_o.six1 = {b[3:0], 2'b00};
        entry_o.two  = cend;
        left_d       = b[3:0];
        grp_d        = GrpThird;
      end
      default: begin
        entry_o.six0 = {left_q, b[7:6]};
        entry_o.six1 = b[5:0];
        entry_o.two  = 1'b1;
        left_d       = '0;
        grp_d        = GrpFirst;
      end
    endcase
    if (cend) begin
      left_d = '0;
      grp_d  = GrpFirst;
      cnt_d  = '0;
    end else begin
      cnt_d  = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q  <= LimRst;
      cnt_q  <= '0;
      grp_q  <= GrpFirst;
      left_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        lim_q <= lim_d;
      end
      if (take_i) begin
        cnt_q  <= cnt_d;
        grp_q  <= grp_d;
        left_q <= left_d;
      end
    end
  end

endmodule

`default_nettype wire

[src/cbe_fifo.sv]
// Short register queue between front and back ends.
`default_nettype none

module cbe_fifo #(
  parameter int unsigned DEPTH = cbe_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_i,
  input  wire cbe_pkg::cbe_entry_t wdata_i,
  output logic             full_o,
  input  wire logic        rd_i,
  output cbe_pkg::cbe_entry_t rdata_o,
  output logic             empty_o
);
  import cbe_pkg::*;

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(DEPTH - 1);

  cbe_entry_t      mem_q [DEPTH];
  logic [AddrW-1:0] wp_q, rp_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == LastAddr) ? '0 : wp_q + 1'b1;
      end
      if (do_rd) begin
        rp_q <= (rp_q == LastAddr) ? '0 : rp_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/cbe_back.sv]
// Back end: splits queue entries into characters and holds the output register.
`default_nettype none

module cbe_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_empty_i,
  input  wire cbe_pkg::cbe_entry_t        q_data_i,
  output logic                            q_rd_o,
  output logic                            empty_o,
  input  wire logic                       pop_i,
  output logic [cbe_pkg::CharW-1:0]       char_code_o,
  output cbe_pkg::cbe_flags_t             flags_o
);
  import cbe_pkg::*;

  logic             vld_q;
  logic             phase_q, phase_d;
  logic [CharW-1:0] char_q, char_d;
  cbe_flags_t       flg_q, flg_d;
  logic             load, fin;

  assign empty_o = !vld_q;
  assign load  = !q_empty_i && (!vld_q || pop_i);
  // last character of the head entry
  assign fin   = phase_q || !q_data_i.two;
  assign q_rd_o = load && fin;

  always_comb begin
    char_d  = sextet_to_ascii(phase_q ? q_data_i.six1 : q_data_i.six0);
    flg_d.chunk_end   = fin && q_data_i.cend;
    flg_d.message_end = fin && q_data_i.cend && q_data_i.mlast;
    flg_d.run_last    = fin;
    phase_d = !fin;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_d;
      flg_q  <= flg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      if (load) begin
        vld_q   <= 1'b1;
        phase_q <= phase_d;
      end else if (pop_i) begin
        vld_q   <= 1'b0;
      end
    end
  end

  assign char_code_o = char_q;
  assign flags_o     = flg_q;

endmodule

`default_nettype wire
